>>> hw/rtl/ffpba_pkg.sv
// ----------------------------------------------------------------------------
// ffpba_pkg
// Shared types and constants for the first-fit page block allocator.
// ----------------------------------------------------------------------------
package ffpba_pkg;

  // table depth and page granularity (page size is a power of two)
  localparam int MAX_ENTRIES = 64;
  localparam int PAGE_BYTES  = 4096;
  localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);

  // field widths
  localparam int ADDR_W     = 32;
  localparam int PAGES_W    = 21;
  localparam int RES_IDX_W  = 6;
  localparam int LIMIT_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int ACTION_W   = 2;

  // table index and entry count widths follow the depth
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = ((CNT_W > LIMIT_W) ? CNT_W : LIMIT_W) + 1;

  // actions
  localparam logic [ACTION_W-1:0] ACT_FIND = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ADD  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LOOK = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_END    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LIMIT = 2'd2;

  // one table entry as stored in the memory
  typedef struct packed {
    logic [ADDR_W-1:0]  start_addr;
    logic [ADDR_W-1:0]  end_addr;
    logic [ADDR_W-1:0]  size;
    logic [PAGES_W-1:0] pages;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // memory access from the sequencer
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
  } ram_req_t;

  // one result item
  typedef struct packed {
    logic                 ok;
    logic [ADDR_W-1:0]    address;
    logic [ADDR_W-1:0]    end_addr;
    logic [ADDR_W-1:0]    size;
    logic [PAGES_W-1:0]   pages;
    logic [RES_IDX_W-1:0] index;
  } result_t;

endpackage

>>> hw/rtl/first_fit_page_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_page_block_allocator
// Block table allocator with first-fit free-area search, append and lookup.
// ----------------------------------------------------------------------------
// One request is worked on at a time; the table lives in a single memory with
// one read and one write port, and find and lookup walk it one entry per
// cycle. A find scans the entries until a gap fits and otherwise checks the
// tail, a lookup scans until it meets the address or the last entry, and an
// add writes one entry; each request holds the block until its result is handed
// on. The result sits in an output register, so a new request is accepted while it waits to be taken.
// The scan of that one memory read port sets the rate. Table writes happen
// only for add, never during a scan, so reads and writes cannot collide.
// Configuration writes are always ready and take effect at once.
// ----------------------------------------------------------------------------
module first_fit_page_block_allocator (
  input  logic                                clk,
  input  logic                                rst,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ffpba_pkg::ACTION_W-1:0]      action,
  input  logic [ffpba_pkg::ADDR_W-1:0]        request_size,
  input  logic [ffpba_pkg::ADDR_W-1:0]        request_address,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                ok,
  output logic [ffpba_pkg::ADDR_W-1:0]        result_address,
  output logic [ffpba_pkg::ADDR_W-1:0]        result_end,
  output logic [ffpba_pkg::ADDR_W-1:0]        result_size,
  output logic [ffpba_pkg::PAGES_W-1:0]       result_pages,
  output logic [ffpba_pkg::RES_IDX_W-1:0]     result_index,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ffpba_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ffpba_pkg::ADDR_W-1:0]        cfg_data
);

  import ffpba_pkg::*;

  logic [ADDR_W-1:0]  heap_start;
  logic [ADDR_W-1:0]  heap_end;
  logic [LIMIT_W-1:0] block_limit;

  ram_req_t ram_req;
  entry_t   ram_rd_data;
  logic     res_valid;
  result_t  res;
  result_t  out_res;
  logic     out_free;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_start  <= '0;
      heap_end    <= '0;
      block_limit <= LIMIT_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HEAP_START:  heap_start  <= cfg_data;
        REG_HEAP_END:    heap_end    <= cfg_data;
        REG_BLOCK_LIMIT: block_limit <= cfg_data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // block table memory
  ffpba_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (ram_rd_data)
  );

  // request sequencer
  ffpba_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .action          (action),
    .request_size    (request_size),
    .request_address (request_address),
    .heap_start      (heap_start),
    .heap_end        (heap_end),
    .block_limit     (block_limit),
    .ram_req         (ram_req),
    .ram_rd_data     (ram_rd_data),
    .res_valid       (res_valid),
    .res             (res),
    .out_free        (out_free)
  );

  // output register
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      out_res <= res;
    end
  end

  assign ok             = out_res.ok;
  assign result_address = out_res.address;
  assign result_end     = out_res.end_addr;
  assign result_size    = out_res.size;
  assign result_pages   = out_res.pages;
  assign result_index   = out_res.index;

endmodule

>>> hw/rtl/ffpba_ram.sv
// ----------------------------------------------------------------------------
// ffpba_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ffpba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/ffpba_ctrl.sv
// ----------------------------------------------------------------------------
// ffpba_ctrl
// Request sequencer: scans the block table in memory one entry per cycle for
// find and lookup, appends entries for add, and builds the result.
// ----------------------------------------------------------------------------
module ffpba_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  // request side
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ffpba_pkg::ACTION_W-1:0]     action,
  input  logic [ffpba_pkg::ADDR_W-1:0]       request_size,
  input  logic [ffpba_pkg::ADDR_W-1:0]       request_address,
  // configuration
  input  logic [ffpba_pkg::ADDR_W-1:0]       heap_start,
  input  logic [ffpba_pkg::ADDR_W-1:0]       heap_end,
  input  logic [ffpba_pkg::LIMIT_W-1:0]      block_limit,
  // table memory
  output ffpba_pkg::ram_req_t                ram_req,
  input  ffpba_pkg::entry_t                  ram_rd_data,
  // result hand-off
  output logic                               res_valid,
  output ffpba_pkg::result_t                 res,
  input  logic                               out_free
);

  import ffpba_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_TAIL = 5'b00100,
    S_ADD  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    entry_count;
  logic [CNT_W-1:0]    ptr;
  logic                rd_pend;
  logic [IDX_W-1:0]    rd_idx;
  logic [ADDR_W-1:0]   prev_end;
  logic [ACTION_W-1:0] req_action;
  logic [ADDR_W-1:0]   req_size;
  logic [ADDR_W-1:0]   req_addr;

  logic                accept;
  logic                issue;
  logic                last;
  logic                gap_hit;
  logic                tail_hit;
  logic                add_ok;
  logic [CMP_W-1:0]    count_ext;
  logic [ADDR_W:0]     pages_full;
  logic [ADDR_W-1:0]   span;
  entry_t              new_entry;
  result_t             fail_res;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign res_valid = (state == S_DONE);

  // read issue while scanning, stop at the entry count
  assign issue = (state == S_SCAN) && (ptr < entry_count);
  assign last  = ((CNT_W'(rd_idx) + CNT_W'(1)) == entry_count);

  // gap before the entry just read (never for entry 0), and the tail after the last entry
  assign gap_hit  = (rd_idx != '0) && ((ram_rd_data.start_addr - prev_end) >= req_size);
  assign tail_hit = ((heap_end - prev_end) >= req_size);

  // table capacity check for add
  assign count_ext = CMP_W'(entry_count);
  assign add_ok    = ((count_ext + CMP_W'(1)) < CMP_W'(block_limit))
                     && (entry_count < CNT_W'(MAX_ENTRIES));

  // page count and end address of a new block
  assign pages_full = (ADDR_W + 1)'(req_size >> PAGE_SHIFT) + (ADDR_W + 1)'(1);
  assign span       = ADDR_W'(pages_full << PAGE_SHIFT);

  always_comb begin
    new_entry.start_addr = req_addr;
    new_entry.end_addr   = req_addr + span;
    new_entry.size       = req_size;
    new_entry.pages      = pages_full[PAGES_W-1:0];
  end

  assign fail_res = '0;

  // memory requests
  always_comb begin
    ram_req.rd_en   = issue;
    ram_req.rd_addr = ptr[IDX_W-1:0];
    ram_req.wr_en   = (state == S_ADD) && add_ok;
    ram_req.wr_addr = entry_count[IDX_W-1:0];
    ram_req.wr_data = new_entry;
  end

  // sequencer control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      rd_pend     <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          rd_pend <= 1'b0;
          if (accept) begin
            case (action)
              ACT_FIND: state <= (entry_count == '0) ? S_TAIL : S_SCAN;
              ACT_ADD:  state <= S_ADD;
              ACT_LOOK: state <= (entry_count == '0) ? S_DONE : S_SCAN;
              default:  state <= S_DONE;
            endcase
          end
        end
        S_SCAN: begin
          rd_pend <= issue;
          if (rd_pend) begin
            if (req_action == ACT_FIND) begin
              if (gap_hit) begin
                state <= S_DONE;
              end else if (last) begin
                state <= S_TAIL;
              end
            end else if ((ram_rd_data.start_addr == req_addr) || last) begin
              state <= S_DONE;
            end
          end
        end
        S_TAIL: begin
          state <= S_DONE;
        end
        S_ADD: begin
          if (add_ok) begin
            entry_count <= entry_count + CNT_W'(1);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // request fields, scan pointer and result
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        ptr      <= '0;
        prev_end <= heap_start;
        res      <= fail_res;
        if (accept) begin
          req_action <= action;
          req_size   <= request_size;
          req_addr   <= request_address;
        end
      end
      S_SCAN: begin
        if (issue) begin
          ptr <= ptr + CNT_W'(1);
        end
        rd_idx <= ptr[IDX_W-1:0];
        if (rd_pend) begin
          if (req_action == ACT_FIND) begin
            if (gap_hit) begin
              res.ok      <= 1'b1;
              res.address <= prev_end;
            end else begin
              prev_end <= ram_rd_data.end_addr;
            end
          end else if (ram_rd_data.start_addr == req_addr) begin
            res.ok       <= 1'b1;
            res.address  <= ram_rd_data.start_addr;
            res.end_addr <= ram_rd_data.end_addr;
            res.size     <= ram_rd_data.size;
            res.pages    <= ram_rd_data.pages;
            res.index    <= RES_IDX_W'(rd_idx);
          end
        end
      end
      S_TAIL: begin
        if (tail_hit) begin
          res.ok      <= 1'b1;
          res.address <= prev_end;
        end
      end
      S_ADD: begin
        if (add_ok) begin
          res.ok       <= 1'b1;
          res.address  <= new_entry.start_addr;
          res.end_addr <= new_entry.end_addr;
          res.size     <= new_entry.size;
          res.pages    <= new_entry.pages;
          res.index    <= RES_IDX_W'(entry_count[IDX_W-1:0]);
        end
      end
      default: begin
      end
    endcase
  end

endmodule
